// ===== hdl/spc_pkg.sv =====
// Shared constants, codes and types of the search probe counter.
package spc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int BIX_W       = CNT_W + 1;
  localparam int VALUE_W     = 32;
  localparam int KIND_W      = 2;
  localparam int LIN_OUT_W   = 11;
  localparam int BIN_OUT_W   = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIN,
    ST_BIN_ISSUE,
    ST_BIN_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

// ===== hdl/search_probe_counter.sv =====
// Top level: table store, search sequencer and result register of the probe counter.
// Load and clear transactions complete in the idle state and the block is ready again next cycle.
// A query scans the table one entry per cycle (RAM read pipelined with the compare),
// then runs the binary search, each probe issuing the midpoint read and then comparing
// the returned entry; the result waits in the done state until the output is free.
// Synchronous active-low reset empties the table and drops any pending result.
module search_probe_counter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [spc_pkg::KIND_W-1:0]            in_kind,
  input  logic signed [spc_pkg::VALUE_W-1:0]    in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [spc_pkg::LIN_OUT_W-1:0]         out_linear_compares,
  output logic [spc_pkg::BIN_OUT_W-1:0]         out_binary_compares
);

  // Sequencer state and control registers.
  spc_pkg::state_t state_r, state_nxt;
  logic [spc_pkg::CNT_W-1:0] count_r, count_nxt;   // entries held in the table
  logic [spc_pkg::CNT_W-1:0] idx_r, idx_nxt;       // next linear address to issue
  logic                      pend_r, pend_nxt;     // read data for a linear entry is due
  logic [spc_pkg::CNT_W-1:0] lin_n_r, lin_n_nxt;
  logic [spc_pkg::BIN_OUT_W-1:0] bin_n_r, bin_n_nxt;
  logic signed [spc_pkg::BIX_W-1:0] first_r, first_nxt;
  logic signed [spc_pkg::BIX_W-1:0] last_r, last_nxt;
  logic [spc_pkg::ADDR_W-1:0] mid_r, mid_nxt;
  logic signed [spc_pkg::VALUE_W-1:0] key_r, key_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [spc_pkg::LIN_OUT_W-1:0] out_lin_r, out_lin_nxt;
  logic [spc_pkg::BIN_OUT_W-1:0] out_bin_r, out_bin_nxt;

  // Datapath wires.
  logic                        accept;
  logic                        ram_wr_en;
  logic [spc_pkg::ADDR_W-1:0]  ram_rd_addr;
  logic [spc_pkg::VALUE_W-1:0] ram_rd_data;
  spc_pkg::cmp_res_t           cmp;
  logic                        lin_more;      // more entries left to issue
  logic                        lin_end;
  logic                        bin_empty;
  logic                        out_free;
  logic signed [spc_pkg::BIX_W:0] mid_sum;
  logic [spc_pkg::ADDR_W-1:0]  mid_addr;
  logic signed [spc_pkg::BIX_W-1:0] mid_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != spc_pkg::ST_IDLE);

  // Table store. Loads write at the fill count, only while there is room.
  assign ram_wr_en = accept && (in_kind == spc_pkg::KIND_LOAD) &&
                     (count_r < spc_pkg::CNT_W'(spc_pkg::TABLE_DEPTH));

  spc_ram #(
    .WIDTH(spc_pkg::VALUE_W),
    .DEPTH(spc_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[spc_pkg::ADDR_W-1:0]),
    .wr_data (in_value),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // One comparator serves both the linear scan and every binary probe.
  spc_cmp u_cmp (
    .probe (ram_rd_data),
    .key   (key_r),
    .res   (cmp)
  );

  // Linear scan ends on a hit or once every entry has been issued and checked.
  assign lin_more = (idx_r < count_r);
  assign lin_end  = (pend_r && cmp.eq) || !lin_more;

  // Binary midpoint: first and last are non-negative whenever the range is open,
  // so floor of the half sum is a plain right shift.
  assign bin_empty = (last_r < first_r);
  assign mid_sum   = {first_r[spc_pkg::BIX_W-1], first_r} + {last_r[spc_pkg::BIX_W-1], last_r};
  assign mid_addr  = mid_sum[spc_pkg::ADDR_W:1];
  assign mid_ext   = $signed({{(spc_pkg::BIX_W - spc_pkg::ADDR_W){1'b0}}, mid_r});

  assign out_free  = !out_valid_r || !out_stall;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spc_pkg::ST_IDLE: begin
        if (accept && (in_kind == spc_pkg::KIND_QUERY)) begin
          state_nxt = spc_pkg::ST_LIN;
        end
      end
      spc_pkg::ST_LIN: begin
        if (lin_end) begin
          state_nxt = spc_pkg::ST_BIN_ISSUE;
        end
      end
      spc_pkg::ST_BIN_ISSUE: begin
        state_nxt = bin_empty ? spc_pkg::ST_DONE : spc_pkg::ST_BIN_CMP;
      end
      spc_pkg::ST_BIN_CMP: begin
        state_nxt = cmp.eq ? spc_pkg::ST_DONE : spc_pkg::ST_BIN_ISSUE;
      end
      spc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = spc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spc_pkg::ST_IDLE;
    endcase
  end

  // Output and datapath logic.
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    lin_n_nxt     = lin_n_r;
    bin_n_nxt     = bin_n_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_lin_nxt   = out_lin_r;
    out_bin_nxt   = out_bin_r;
    out_valid_nxt = out_valid_r && out_stall;   // drop once taken
    ram_rd_addr   = idx_r[spc_pkg::ADDR_W-1:0];
    case (state_r)
      spc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            spc_pkg::KIND_LOAD: begin
              if (ram_wr_en) begin
                count_nxt = count_r + spc_pkg::CNT_W'(1);
              end
            end
            spc_pkg::KIND_CLEAR: begin
              count_nxt = '0;
            end
            spc_pkg::KIND_QUERY: begin
              key_nxt   = in_value;
              idx_nxt   = '0;
              lin_n_nxt = '0;
              bin_n_nxt = '0;
            end
            default: begin
              // unused kind: nothing to do
            end
          endcase
        end
      end
      spc_pkg::ST_LIN: begin
        // Count the entry whose data arrives, issue the next address.
        if (pend_r) begin
          lin_n_nxt = lin_n_r + spc_pkg::CNT_W'(1);
        end
        if (lin_end) begin
          first_nxt = '0;
          last_nxt  = $signed({1'b0, count_r}) - spc_pkg::BIX_W'(1);
        end else begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + spc_pkg::CNT_W'(1);
        end
      end
      spc_pkg::ST_BIN_ISSUE: begin
        ram_rd_addr = mid_addr;
        mid_nxt     = mid_addr;
      end
      spc_pkg::ST_BIN_CMP: begin
        bin_n_nxt = bin_n_r + spc_pkg::BIN_OUT_W'(1);
        if (!cmp.eq) begin
          if (cmp.gt) begin
            last_nxt = mid_ext - spc_pkg::BIX_W'(1);
          end else begin
            first_nxt = mid_ext + spc_pkg::BIX_W'(1);
          end
        end
      end
      spc_pkg::ST_DONE: begin
        // Hold the result until the output register frees up.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_lin_nxt   = spc_pkg::LIN_OUT_W'(lin_n_r);
          out_bin_nxt   = bin_n_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spc_pkg::ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    lin_n_r   <= lin_n_nxt;
    bin_n_r   <= bin_n_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    mid_r     <= mid_nxt;
    key_r     <= key_nxt;
    out_lin_r <= out_lin_nxt;
    out_bin_r <= out_bin_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_linear_compares = out_lin_r;
  assign out_binary_compares = out_bin_r;

endmodule

// ===== hdl/spc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/spc_cmp.sv =====
// Shared comparator: equality and signed greater-than of a probe against the key.
module spc_cmp (
  input  logic signed [spc_pkg::VALUE_W-1:0] probe,
  input  logic signed [spc_pkg::VALUE_W-1:0] key,
  output spc_pkg::cmp_res_t                  res
);

  always_comb begin
    res.eq = (probe == key);
    res.gt = (probe > key);
  end

endmodule
